[design/tterm_pkg.sv]
// ----------------------------------------------------------------------------
// tterm_pkg
// Shared types, command codes and helper functions for the text terminal
// escape writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tterm_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;

    // result command codes
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_BLANK  = 3'd1;
    localparam logic [2:0] CMD_SCROLL = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_CURSOR = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMNS         = 2'd0;
    localparam logic [1:0] REG_ROWS            = 2'd1;
    localparam logic [1:0] REG_DEFAULT_ATTR    = 2'd2;
    localparam logic [1:0] REG_OUTPUT_DISABLED = 2'd3;

    // select graphic rendition codes
    localparam logic [7:0] SGR_RESET        = 8'd0;
    localparam logic [7:0] SGR_BOLD         = 8'd1;
    localparam logic [7:0] SGR_FG_FIRST     = 8'd30;
    localparam logic [7:0] SGR_FG_LAST      = 8'd37;
    localparam logic [7:0] SGR_BRIGHT_FIRST = 8'd90;
    localparam logic [7:0] SGR_BRIGHT_LAST  = 8'd97;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] columns;
        logic [6:0] rows;
        logic [7:0] default_attr;
        logic       output_disabled;
    } cfg_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       first_of_write;
        logic       last_of_write;
        logic       at_cursor;
        logic [6:0] start_col;
        logic [5:0] start_row;
    } item_t;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] cell_col;
        logic [5:0] cell_row;
        logic [7:0] glyph;
        logic [7:0] attr_out;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] entry;
        logic    [1:0]             count;
    } bundle_t;

    typedef struct packed {
        logic [7:0] attr;
        logic       bold;
    } sgr_t;

    // decimal accumulate, saturating at 255
    function automatic logic [7:0] sat_digit(logic [7:0] p, logic [3:0] d);
        logic [11:0] v;
        v = 12'(p) * 12'd10 + 12'(d);
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

    // vga colour order is the ansi index with its three bits reversed
    function automatic logic [2:0] vga_colour(logic [2:0] idx);
        return {idx[0], idx[1], idx[2]};
    endfunction

    function automatic sgr_t apply_sgr(logic [7:0] code, sgr_t cur);
        sgr_t       r;
        logic       fg_valid;
        logic [3:0] fg;
        r        = cur;
        fg_valid = 1'b0;
        fg       = 4'h0;
        if (code == SGR_RESET) begin
            r.bold   = 1'b0;
            fg_valid = 1'b1;
            fg       = 4'hF;
        end else if (code == SGR_BOLD) begin
            r.bold    = 1'b1;
            r.attr[3] = 1'b1;
        end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
            fg_valid = 1'b1;
            fg       = {cur.bold, vga_colour(3'(code - SGR_FG_FIRST))};
        end else if (code >= SGR_BRIGHT_FIRST && code <= SGR_BRIGHT_LAST) begin
            fg_valid = 1'b1;
            fg       = {1'b1, vga_colour(3'(code - SGR_BRIGHT_FIRST))};
        end
        if (fg_valid) begin
            r.attr[3:0] = fg;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/tterm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tterm_cfg_regs
// Configuration register file: screen size, default attribute and the
// output disable flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tterm_cfg_regs (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [7:0]      cfg_data,
    output tterm_pkg::cfg_t      cfg
);
    import tterm_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns         <= 8'd80;
            cfg_reg.rows            <= 7'd25;
            cfg_reg.default_attr    <= 8'h0F;
            cfg_reg.output_disabled <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_COLUMNS:         cfg_reg.columns         <= cfg_data;
                REG_ROWS:            cfg_reg.rows            <= cfg_data[6:0];
                REG_DEFAULT_ATTR:    cfg_reg.default_attr    <= cfg_data;
                REG_OUTPUT_DISABLED: cfg_reg.output_disabled <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/tterm_core.sv]
// ----------------------------------------------------------------------------
// tterm_core
// Escape parser, cursor and attribute state. Turns one registered text
// byte combinationally into up to three result words.
// ----------------------------------------------------------------------------
`default_nettype none

module tterm_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tterm_pkg::cfg_t cfg,
    input  wire tterm_pkg::item_t item,
    input  wire logic            step,
    output tterm_pkg::bundle_t   bundle
);
    import tterm_pkg::*;

    localparam logic [2:0] PS_TEXT   = 3'd0;
    localparam logic [2:0] PS_ESC    = 3'd1;
    localparam logic [2:0] PS_CSI    = 3'd2;
    localparam logic [2:0] PS_PARAM1 = 3'd3;
    localparam logic [2:0] PS_PARAM2 = 3'd4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_UP    = 8'h41;
    localparam logic [7:0] CH_RIGHT = 8'h43;
    localparam logic [7:0] CH_HOME  = 8'h48;
    localparam logic [7:0] CH_CLEAR = 8'h4A;
    localparam logic [7:0] CH_HVP   = 8'h66;
    localparam logic [7:0] CH_SGR   = 8'h6D;

    logic [6:0] cursor_col_reg, cursor_col_next;
    logic [5:0] cursor_row_reg, cursor_row_next;
    logic [6:0] work_col_reg;
    logic [5:0] work_row_reg;
    sgr_t       sgr_reg, sgr_next;
    logic [2:0] parse_state_reg, parse_state_next;
    logic [7:0] first_param_reg, first_param_next;
    logic [7:0] second_param_reg, second_param_next;

    logic [7:0] ncol;
    logic [6:0] nrow;
    logic [6:0] col_max;
    logic [5:0] row_max;
    logic [2:0] ps;
    logic [6:0] wcol;
    logic [5:0] wrow;
    logic [8:0] col;
    logic [6:0] row;
    logic [7:0] b;
    logic       is_digit;
    logic       text;
    logic       ev_valid;
    result_t    ev;
    logic       scroll;
    logic [7:0] tcol;
    logic [7:0] trow;
    logic [1:0] n;
    result_t [MAX_RESULTS-1:0] list;

    assign ncol = (cfg.columns == 8'd0) ? 8'd1 :
                  (cfg.columns > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : cfg.columns;
    assign nrow = (cfg.rows == 7'd0) ? 7'd1 :
                  (cfg.rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg.rows;
    assign col_max = 7'(ncol - 8'd1);
    assign row_max = 6'(nrow - 7'd1);
    assign b        = item.char_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

    always_comb begin
        ps   = parse_state_reg;
        wcol = work_col_reg;
        wrow = work_row_reg;
        if (item.first_of_write) begin
            ps = PS_TEXT;
            if (item.at_cursor) begin
                wcol = cursor_col_reg;
                wrow = cursor_row_reg;
            end else begin
                wcol = item.start_col;
                wrow = item.start_row;
            end
        end
        col = 9'((wcol > col_max) ? col_max : wcol);
        row = 7'((wrow > row_max) ? row_max : wrow);

        parse_state_next  = ps;
        first_param_next  = first_param_reg;
        second_param_next = second_param_reg;
        sgr_next          = sgr_reg;
        cursor_col_next   = cursor_col_reg;
        cursor_row_next   = cursor_row_reg;
        text              = 1'b0;
        ev_valid          = 1'b0;
        ev                = '0;
        scroll            = 1'b0;
        tcol              = 8'd0;
        trow              = 8'd0;

        unique case (ps)
            PS_ESC: begin
                if (b == CH_LBRK) begin
                    parse_state_next  = PS_CSI;
                    first_param_next  = 8'd0;
                    second_param_next = 8'd0;
                end else begin
                    parse_state_next = PS_TEXT;
                    text             = 1'b1;
                end
            end
            PS_CSI, PS_PARAM1: begin
                parse_state_next = PS_TEXT;
                priority if (ps == PS_CSI && b == CH_HOME) begin
                    col = 9'd0;
                    row = 7'd0;
                end else if (ps == PS_CSI && b == CH_CLEAR) begin
                    ev_valid        = 1'b1;
                    ev.command      = CMD_CLEAR;
                    ev.glyph        = CH_SPACE;
                    ev.attr_out     = sgr_reg.attr;
                    cursor_col_next = 7'd0;
                    cursor_row_next = 6'd0;
                end else if (ps == PS_CSI && b == CH_SGR) begin
                    sgr_next.attr[3:0] = cfg.default_attr[3:0];
                end else if (is_digit) begin
                    first_param_next = sat_digit(first_param_reg, 4'(b - CH_ZERO));
                    parse_state_next = PS_PARAM1;
                end else if (b == CH_SEMI) begin
                    second_param_next = 8'd0;
                    parse_state_next  = PS_PARAM2;
                end else if (b == CH_SGR) begin
                    sgr_next = apply_sgr(first_param_reg, sgr_reg);
                end else if (b == CH_UP) begin
                    row = ({1'b0, row} >= first_param_reg) ?
                          7'(8'(row) - first_param_reg) : 7'd0;
                end else if (b == CH_RIGHT) begin
                    col = col + 9'(first_param_reg);
                    if (col > 9'(col_max)) begin
                        col = 9'(col_max);
                    end
                end else begin
                    // unknown final byte ends the sequence
                end
            end
            PS_PARAM2: begin
                if (is_digit) begin
                    second_param_next = sat_digit(second_param_reg, 4'(b - CH_ZERO));
                end else begin
                    parse_state_next = PS_TEXT;
                    if (b == CH_HOME || b == CH_HVP) begin
                        tcol = (second_param_reg != 8'd0) ? second_param_reg - 8'd1 : 8'd0;
                        trow = (first_param_reg != 8'd0) ? first_param_reg - 8'd1 : 8'd0;
                        col  = 9'((tcol > 8'(col_max)) ? 8'(col_max) : tcol);
                        row  = 7'((trow > 8'(row_max)) ? 8'(row_max) : trow);
                    end else if (b == CH_SGR) begin
                        sgr_next = apply_sgr(second_param_reg,
                                             apply_sgr(first_param_reg, sgr_reg));
                    end
                end
            end
            default: begin
                parse_state_next = PS_TEXT;
                text             = 1'b1;
            end
        endcase

        if (text) begin
            priority if (b == CH_LF || b == CH_CR) begin
                col = 9'd0;
                row = row + 7'd1;
            end else if (b == CH_TAB) begin
                col = col + 9'd4;
            end else if (b == CH_ESC) begin
                parse_state_next  = PS_ESC;
                first_param_next  = 8'd0;
                second_param_next = 8'd0;
            end else if (b == CH_BS) begin
                if (col != 9'd0) begin
                    ev_valid    = 1'b1;
                    ev.command  = CMD_BLANK;
                    ev.cell_col = 7'(col - 9'd1);
                    ev.cell_row = row[5:0];
                    ev.glyph    = CH_SPACE;
                    col         = col - 9'd1;
                end
            end else begin
                ev_valid    = 1'b1;
                ev.command  = CMD_WRITE;
                ev.cell_col = col[6:0];
                ev.cell_row = row[5:0];
                ev.glyph    = b;
                ev.attr_out = sgr_reg.attr;
                col         = col + 9'd1;
            end
        end

        if (col >= 9'(ncol)) begin
            col = 9'd0;
            row = row + 7'd1;
        end
        if (row >= nrow) begin
            scroll = 1'b1;
            col    = 9'd0;
            row    = 7'(row_max);
        end
        if (item.at_cursor) begin
            cursor_col_next = col[6:0];
            cursor_row_next = row[5:0];
        end
    end

    // pack the results in issue order
    always_comb begin
        n    = 2'd0;
        list = '0;
        if (ev_valid) begin
            list[n] = ev;
            n       = n + 2'd1;
        end
        if (scroll) begin
            list[n].command = CMD_SCROLL;
            n               = n + 2'd1;
        end
        if (item.last_of_write) begin
            list[n].command  = CMD_CURSOR;
            list[n].cell_col = cursor_col_next;
            list[n].cell_row = cursor_row_next;
            n                = n + 2'd1;
        end
    end

    assign bundle.entry = list;
    assign bundle.count = cfg.output_disabled ? 2'd0 : n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg   <= 7'd0;
            cursor_row_reg   <= 6'd0;
            work_col_reg     <= 7'd0;
            work_row_reg     <= 6'd0;
            sgr_reg.attr     <= 8'h0F;
            sgr_reg.bold     <= 1'b0;
            parse_state_reg  <= PS_TEXT;
            first_param_reg  <= 8'd0;
            second_param_reg <= 8'd0;
        end else if (step && !cfg.output_disabled) begin
            cursor_col_reg   <= cursor_col_next;
            cursor_row_reg   <= cursor_row_next;
            work_col_reg     <= col[6:0];
            work_row_reg     <= row[5:0];
            sgr_reg          <= sgr_next;
            parse_state_reg  <= parse_state_next;
            first_param_reg  <= first_param_next;
            second_param_reg <= second_param_next;
        end
    end

endmodule

`default_nettype wire

[design/tterm_out_queue.sv]
// ----------------------------------------------------------------------------
// tterm_out_queue
// Result register: holds the words of one byte and hands them out one per
// cycle while m_ready is high, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module tterm_out_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tterm_pkg::bundle_t bundle,
    input  wire logic            load,
    output logic                 load_ok,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [2:0]           m_command,
    output logic [6:0]           m_cell_col,
    output logic [5:0]           m_cell_row,
    output logic [7:0]           m_glyph,
    output logic [7:0]           m_attr_out,
    output logic                 m_last
);
    import tterm_pkg::*;

    result_t [MAX_RESULTS-1:0] entry_reg;
    logic    [1:0]             count_reg;
    logic    [1:0]             idx_reg;
    logic                      last_sel;
    logic                      pop;
    result_t                   cur;

    assign cur      = entry_reg[idx_reg];
    assign last_sel = (idx_reg == count_reg - 2'd1);
    assign m_valid  = (count_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign load_ok  = !m_valid || (m_ready && last_sel);

    assign m_command  = cur.command;
    assign m_cell_col = cur.cell_col;
    assign m_cell_row = cur.cell_row;
    assign m_glyph    = cur.glyph;
    assign m_attr_out = cur.attr_out;
    assign m_last     = last_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            count_reg <= bundle.count;
            idx_reg   <= 2'd0;
        end else if (pop) begin
            if (last_sel) begin
                count_reg <= 2'd0;
                idx_reg   <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= bundle.entry;
        end
    end

endmodule

`default_nettype wire

[design/text_terminal_escape_writer.sv]
// ----------------------------------------------------------------------------
// text_terminal_escape_writer
// Text byte stream to character-cell screen commands, with an escape
// sequence parser for cursor moves, clear screen and colour attributes.
// ----------------------------------------------------------------------------
//  channel   ports        word
//  s_        input        one text byte with write framing and start position
//  m_        output       one screen command, m_last on the final one of a byte
//  cfg_      config       register index and data, always ready
//
//  a byte waits in the input register until the result register can load,
//  and is parsed combinationally into up to three words for that register
//  one byte per cycle is taken while m_ready is high and each byte gives at
//  most one word; a byte giving more words holds the input until its last
//  word is sent, as the result register sends one word per cycle on m_ready
//  reset clears parser, cursor and attribute state; no clearing pass
//  m_ready low holds the result register, and then the input register fills
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_escape_writer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_byte,
    input  wire logic        s_first_of_write,
    input  wire logic        s_last_of_write,
    input  wire logic        s_at_cursor,
    input  wire logic [6:0]  s_start_col,
    input  wire logic [5:0]  s_start_row,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_command,
    output logic [6:0]       m_cell_col,
    output logic [5:0]       m_cell_row,
    output logic [7:0]       m_glyph,
    output logic [7:0]       m_attr_out,
    output logic             m_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import tterm_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    step;
    logic    load_ok;
    bundle_t bundle;

    assign step    = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.char_byte      <= s_char_byte;
            item_reg.first_of_write <= s_first_of_write;
            item_reg.last_of_write  <= s_last_of_write;
            item_reg.at_cursor      <= s_at_cursor;
            item_reg.start_col      <= s_start_col;
            item_reg.start_row      <= s_start_row;
        end
    end

    tterm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tterm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .step    (step),
        .bundle  (bundle)
    );

    tterm_out_queue u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bundle     (bundle),
        .load       (step),
        .load_ok    (load_ok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_command  (m_command),
        .m_cell_col (m_cell_col),
        .m_cell_row (m_cell_row),
        .m_glyph    (m_glyph),
        .m_attr_out (m_attr_out),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire

[design/tterm_checker.sv]
// ----------------------------------------------------------------------------
// tterm_checker
// Port-level checks on the result stream of the text terminal writer.
// ----------------------------------------------------------------------------
`default_nettype none

module tterm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_command,
    input wire logic [6:0]  m_cell_col,
    input wire logic [5:0]  m_cell_row,
    input wire logic        m_last
);
    import tterm_pkg::*;

    // a pending word is never withdrawn
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // the words of one byte leave back to back
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside the words of one byte");

    // scroll and clear carry no position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_command == CMD_SCROLL || m_command == CMD_CLEAR)
        |-> m_cell_col == 7'd0 && m_cell_row == 6'd0)
        else $error("scroll or clear with a cell position");

    // the cursor report closes a byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command == CMD_CURSOR |-> m_last)
        else $error("cursor report not final word");

    // input is taken only when the result side can make room
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && $past(s_valid && s_ready) && $past(m_valid && !m_ready)
        |-> !s_ready)
        else $error("input taken with both stages full");

endmodule

bind text_terminal_escape_writer tterm_checker u_checker (.*);

`default_nettype wire
